FILE: hdl/tctd_pkg.sv
`timescale 1ns / 1ps

package tctd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF   = 16;
    localparam int NUM_CLASSES     = 3;
    localparam int CLASS_W         = 2;
    localparam int LIMIT_W         = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CMD_DEPTH       = 2;

    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST   = 4'd2;
    localparam logic [LIMIT_W-1:0] MIDDLE_LIMIT_RST = 4'd1;
    localparam logic [LIMIT_W-1:0] RUN_MAX          = 4'd15;

    typedef enum logic {
        OP_ENQUEUE  = 1'b0,
        OP_DISPATCH = 1'b1
    } t_op;

    typedef enum logic [CLASS_W-1:0] {
        CLS_HIGH   = 2'd0,
        CLS_MIDDLE = 2'd1,
        CLS_LOW    = 2'd2,
        CLS_NONE   = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        ST_ENQUEUED   = 2'd0,
        ST_DROPPED    = 2'd1,
        ST_DISPATCHED = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_LIMIT   = 1'b0,
        CFG_MIDDLE_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_FETCH = 2'b10
    } t_back_state;

    typedef struct packed {
        t_op    op;
        t_class cls;
    } t_cmd;

    function automatic int pad_bytes(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

FILE: hdl/tctd_front.sv
`timescale 1ns / 1ps

module tctd_front #(
    parameter int TAG_WIDTH = tctd_pkg::TAG_WIDTH_DEF,
    parameter int IN_W      = tctd_pkg::pad_bytes(TAG_WIDTH + tctd_pkg::CLASS_W)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_pop,
    output tctd_pkg::t_cmd       o_cmd,
    output logic [TAG_WIDTH-1:0] o_cmd_tag
);
    import tctd_pkg::*;

    localparam int CMD_AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CW = $clog2(CMD_DEPTH + 1);

    t_cmd                 r_q_cmd [CMD_DEPTH];
    logic [TAG_WIDTH-1:0] r_q_tag [CMD_DEPTH];
    logic [CMD_AW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [CMD_CW-1:0]    r_cnt, n_cnt;
    logic                 push;
    t_cmd                 n_cmd;

    // classify the incoming beat
    always_comb begin
        n_cmd.op  = t_op'(s_axis_tuser);
        n_cmd.cls = t_class'(s_axis_tdata[TAG_WIDTH +: CLASS_W]);
    end

    assign s_axis_tready = (r_cnt != CMD_CW'(CMD_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_cnt != '0);
    assign o_cmd         = r_q_cmd[r_rp];
    assign o_cmd_tag     = r_q_tag[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = (r_wp == CMD_AW'(CMD_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rp = (r_rp == CMD_AW'(CMD_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (push && !i_cmd_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_cmd[r_wp] <= n_cmd;
            r_q_tag[r_wp] <= s_axis_tdata[TAG_WIDTH-1:0];
        end
    end

endmodule

FILE: hdl/tctd_back.sv
`timescale 1ns / 1ps

module tctd_back #(
    parameter int QUEUE_DEPTH = tctd_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = tctd_pkg::TAG_WIDTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tctd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tctd_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  logic                            i_cmd_valid,
    output logic                            o_cmd_pop,
    input  tctd_pkg::t_cmd                  i_cmd,
    input  logic [TAG_WIDTH-1:0]            i_cmd_tag,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output tctd_pkg::t_status               o_res_status,
    output logic [TAG_WIDTH-1:0]            o_res_tag,
    output tctd_pkg::t_class                o_res_class,
    output logic [CNT_W-1:0]                o_res_occ_high,
    output logic [CNT_W-1:0]                o_res_occ_middle,
    output logic [CNT_W-1:0]                o_res_occ_low
);
    import tctd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_back_state          r_state, n_state;
    logic [LIMIT_W-1:0]   r_hlim, r_mlim;
    logic [LIMIT_W-1:0]   r_hrun, r_mrun, n_hrun, n_mrun;
    logic [CNT_W-1:0]     r_cnt [NUM_CLASSES];
    logic [CNT_W-1:0]     n_cnt [NUM_CLASSES];
    logic [PTR_W-1:0]     r_wp  [NUM_CLASSES];
    logic [PTR_W-1:0]     n_wp  [NUM_CLASSES];
    logic [PTR_W-1:0]     r_rp  [NUM_CLASSES];
    logic [PTR_W-1:0]     n_rp  [NUM_CLASSES];
    logic [TAG_WIDTH-1:0] r_rd  [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] we, re, nz, full;
    t_class               sel_cls, r_pend_cls, n_pend_cls;
    logic                 sel_ok, out_free, load_out, issue, enq_ok;

    logic                 r_out_valid;
    t_status              r_out_status, n_out_status;
    logic [TAG_WIDTH-1:0] r_out_tag, n_out_tag, fetch_tag;
    t_class               r_out_cls, n_out_cls;
    logic [CNT_W-1:0]     r_out_occ [NUM_CLASSES];
    logic [CNT_W-1:0]     n_out_occ [NUM_CLASSES];

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [LIMIT_W-1:0] bump(input logic [LIMIT_W-1:0] r);
        return (r == RUN_MAX) ? RUN_MAX : r + 1'b1;
    endfunction

    always_comb begin
        for (int k = 0; k < NUM_CLASSES; k++) begin
            nz[k]   = (r_cnt[k] != '0);
            full[k] = (r_cnt[k] == CNT_W'(QUEUE_DEPTH));
        end
    end

    // weighted class pick
    always_comb begin
        sel_ok = 1'b1;
        priority if (nz[0] && ((r_hrun < r_hlim) || !nz[1] || !nz[2])) begin
            sel_cls = CLS_HIGH;
        end else if (nz[1] && ((r_mrun < r_mlim) || !nz[2])) begin
            sel_cls = CLS_MIDDLE;
        end else if (nz[2]) begin
            sel_cls = CLS_LOW;
        end else begin
            sel_cls = CLS_NONE;
            sel_ok  = 1'b0;
        end
    end

    always_comb begin
        unique case (r_pend_cls)
            CLS_HIGH:   fetch_tag = r_rd[0];
            CLS_MIDDLE: fetch_tag = r_rd[1];
            CLS_LOW:    fetch_tag = r_rd[2];
            default:    fetch_tag = '0;
        endcase
    end

    assign out_free = !r_out_valid || i_res_ready;

    always_comb begin
        n_state      = r_state;
        n_hrun       = r_hrun;
        n_mrun       = r_mrun;
        n_cnt        = r_cnt;
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_pend_cls   = r_pend_cls;
        we           = '0;
        re           = '0;
        o_cmd_pop    = 1'b0;
        load_out     = 1'b0;
        issue        = 1'b0;
        enq_ok       = 1'b0;
        n_out_status = r_out_status;
        n_out_tag    = r_out_tag;
        n_out_cls    = r_out_cls;
        n_out_occ    = r_out_occ;
        unique case (r_state)
            S_RUN: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_ENQUEUE) begin
                        for (int k = 0; k < NUM_CLASSES; k++) begin
                            if (i_cmd.cls == t_class'(CLASS_W'(k)) && !full[k]) begin
                                enq_ok   = 1'b1;
                                we[k]    = 1'b1;
                                n_cnt[k] = r_cnt[k] + 1'b1;
                                n_wp[k]  = adv(r_wp[k]);
                            end
                        end
                        load_out     = 1'b1;
                        n_out_status = enq_ok ? ST_ENQUEUED : ST_DROPPED;
                        n_out_tag    = '0;
                        n_out_cls    = CLS_HIGH;
                    end else if (sel_ok) begin
                        for (int k = 0; k < NUM_CLASSES; k++) begin
                            if (sel_cls == t_class'(CLASS_W'(k))) begin
                                re[k]    = 1'b1;
                                n_cnt[k] = r_cnt[k] - 1'b1;
                                n_rp[k]  = adv(r_rp[k]);
                            end
                        end
                        unique case (sel_cls)
                            CLS_HIGH: begin
                                n_hrun = bump(r_hrun);
                                n_mrun = '0;
                            end
                            CLS_MIDDLE: begin
                                n_mrun = bump(r_mrun);
                                n_hrun = '0;
                            end
                            default: begin
                                n_hrun = '0;
                                n_mrun = '0;
                            end
                        endcase
                        issue      = 1'b1;
                        n_pend_cls = sel_cls;
                        n_state    = S_FETCH;
                    end else begin
                        load_out     = 1'b1;
                        n_out_status = ST_EMPTY;
                        n_out_tag    = '0;
                        n_out_cls    = CLS_HIGH;
                    end
                    if (n_cnt[0] == '0 && n_cnt[1] == '0 && n_cnt[2] == '0) begin
                        n_hrun = '0;
                        n_mrun = '0;
                    end
                    n_out_occ = n_cnt;
                end
            end
            S_FETCH: begin
                if (out_free) begin
                    load_out     = 1'b1;
                    n_out_status = ST_DISPATCHED;
                    n_out_tag    = fetch_tag;
                    n_out_cls    = r_pend_cls;
                    n_out_occ    = r_cnt;
                    n_state      = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_hlim      <= HIGH_LIMIT_RST;
            r_mlim      <= MIDDLE_LIMIT_RST;
            r_hrun      <= '0;
            r_mrun      <= '0;
            r_pend_cls  <= CLS_NONE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++) begin
                r_cnt[k] <= '0;
                r_wp[k]  <= '0;
                r_rp[k]  <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_hrun     <= n_hrun;
            r_mrun     <= n_mrun;
            r_pend_cls <= n_pend_cls;
            r_cnt      <= n_cnt;
            r_wp       <= n_wp;
            r_rp       <= n_rp;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_HIGH_LIMIT:   r_hlim <= i_cfg_data;
                    CFG_MIDDLE_LIMIT: r_mlim <= i_cfg_data;
                    default:          r_hlim <= r_hlim;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= n_out_status;
            r_out_tag    <= n_out_tag;
            r_out_cls    <= n_out_cls;
            r_out_occ    <= n_out_occ;
        end
    end

    // one tag store per class
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_store
        logic [TAG_WIDTH-1:0] r_mem [QUEUE_DEPTH];

        always_ff @(posedge i_clk) begin
            if (we[g]) begin
                r_mem[r_wp[g]] <= i_cmd_tag;
            end
            if (re[g]) begin
                r_rd[g] <= r_mem[r_rp[g]];
            end
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_res_status     = r_out_status;
    assign o_res_tag        = r_out_tag;
    assign o_res_class      = r_out_cls;
    assign o_res_occ_high   = r_out_occ[0];
    assign o_res_occ_middle = r_out_occ[1];
    assign o_res_occ_low    = r_out_occ[2];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] <= CNT_W'(QUEUE_DEPTH)) && (r_cnt[1] <= CNT_W'(QUEUE_DEPTH))
        && (r_cnt[2] <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[0] == '0 && r_cnt[1] == '0 && r_cnt[2] == '0)
        |-> (r_hrun == '0 && r_mrun == '0))
        else $error("run count left with all queues empty");

    a_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> (r_state == S_FETCH && r_pend_cls != CLS_NONE))
        else $error("dispatch without a fetch of a real class");

    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (i_cmd_valid && r_state == S_RUN))
        else $error("command taken from an empty queue");
`endif

endmodule

FILE: hdl/three_class_weighted_task_dispatcher.sv
`timescale 1ns / 1ps

// channel  | direction | tdata (low bit up)                          | tuser
// s_axis   | in        | task_tag, task_class                        | operation
// m_axis   | out       | out_tag, out_class, high/middle/low_occupancy | status
// cfg      | in        | i_cfg_we, i_cfg_idx (0 high limit, 1 middle limit), i_cfg_data
//
// a beat is registered in the two-entry command queue before the back end takes it
// enqueue and empty dispatch finish in S_RUN, so they run one beat a cycle unless m_axis stalls
// a dispatch that pops a tag goes through S_RUN and then S_FETCH, as the tag store read is registered
// reset (synchronous) empties the queues, clears run counts, limits go to 2 and 1
// a stalled result holds the back end; the command queue fills, then s_axis_tready drops

module three_class_weighted_task_dispatcher #(
    parameter int QUEUE_DEPTH = tctd_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = tctd_pkg::TAG_WIDTH_DEF,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int IN_W        = tctd_pkg::pad_bytes(TAG_WIDTH + tctd_pkg::CLASS_W),
    parameter int OUT_W       = tctd_pkg::pad_bytes(TAG_WIDTH + tctd_pkg::CLASS_W + 3 * CNT_W)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tctd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tctd_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_W-1:0]                s_axis_tdata,  // task_tag, task_class
    input  logic                           s_axis_tuser,  // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [OUT_W-1:0]               m_axis_tdata,  // out_tag, out_class, occupancies
    output logic [1:0]                     m_axis_tuser   // status
);
    import tctd_pkg::*;

    logic                 cmd_valid, cmd_pop;
    t_cmd                 cmd;
    logic [TAG_WIDTH-1:0] cmd_tag;
    t_status              res_status;
    logic [TAG_WIDTH-1:0] res_tag;
    t_class               res_class;
    logic [CNT_W-1:0]     occ_high, occ_middle, occ_low;

    tctd_front #(
        .TAG_WIDTH (TAG_WIDTH),
        .IN_W      (IN_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_pop     (cmd_pop),
        .o_cmd         (cmd),
        .o_cmd_tag     (cmd_tag)
    );

    tctd_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH),
        .CNT_W       (CNT_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_cmd_valid      (cmd_valid),
        .o_cmd_pop        (cmd_pop),
        .i_cmd            (cmd),
        .i_cmd_tag        (cmd_tag),
        .o_res_valid      (m_axis_tvalid),
        .i_res_ready      (m_axis_tready),
        .o_res_status     (res_status),
        .o_res_tag        (res_tag),
        .o_res_class      (res_class),
        .o_res_occ_high   (occ_high),
        .o_res_occ_middle (occ_middle),
        .o_res_occ_low    (occ_low)
    );

    assign m_axis_tdata = OUT_W'({occ_low, occ_middle, occ_high, res_class, res_tag});
    assign m_axis_tuser = res_status;

endmodule

FILE: verif/three_class_weighted_task_dispatcher_test.sv
`timescale 1ns / 1ps

module three_class_weighted_task_dispatcher_test;

    import tctd_pkg::*;

    localparam int TAG_W = 16;
    localparam int OCC_W = 5;
    localparam int IN_W  = 24;
    localparam int OUT_W = 40;
    localparam int DEPTH = 16;

    typedef struct packed {
        t_status          status;
        logic [TAG_W-1:0] tag;
        t_class           cls;
        logic [OCC_W-1:0] high_occ;
        logic [OCC_W-1:0] middle_occ;
        logic [OCC_W-1:0] low_occ;
    } t_reply;

    class t_dispatch_shadow;
        logic [TAG_W-1:0]   waiting[NUM_CLASSES][$];
        logic [LIMIT_W-1:0] high_limit;
        logic [LIMIT_W-1:0] middle_limit;
        logic [LIMIT_W-1:0] high_run;
        logic [LIMIT_W-1:0] middle_run;
        t_reply             pending[$];
        int                 faults;

        function new();
            high_limit   = HIGH_LIMIT_RST;
            middle_limit = MIDDLE_LIMIT_RST;
            high_run     = '0;
            middle_run   = '0;
            faults       = 0;
        endfunction

        function void set_limit(t_cfg_idx idx, logic [LIMIT_W-1:0] value);
            if (idx == CFG_HIGH_LIMIT) begin
                high_limit = value;
            end else begin
                middle_limit = value;
            end
        endfunction

        function void accept_item(t_op op, logic [TAG_W-1:0] tag, logic [CLASS_W-1:0] cls);
            t_reply r;
            bit     h;
            bit     m;
            bit     l;
            r.status = ST_ENQUEUED;
            r.tag    = '0;
            r.cls    = CLS_HIGH;
            if (op == OP_ENQUEUE) begin
                if (cls == CLS_NONE || waiting[cls].size() >= DEPTH) begin
                    r.status = ST_DROPPED;
                end else begin
                    waiting[cls].push_back(tag);
                end
            end else begin
                h = waiting[CLS_HIGH].size() != 0;
                m = waiting[CLS_MIDDLE].size() != 0;
                l = waiting[CLS_LOW].size() != 0;
                r.status = ST_DISPATCHED;
                if (h && (high_run < high_limit || !m || !l)) begin
                    r.cls = CLS_HIGH;
                    high_run = (high_run == RUN_MAX) ? RUN_MAX : high_run + 1'b1;
                    middle_run = '0;
                end else if (m && (middle_run < middle_limit || !l)) begin
                    r.cls = CLS_MIDDLE;
                    middle_run = (middle_run == RUN_MAX) ? RUN_MAX : middle_run + 1'b1;
                    high_run = '0;
                end else if (l) begin
                    r.cls = CLS_LOW;
                    high_run = '0;
                    middle_run = '0;
                end else begin
                    r.status = ST_EMPTY;
                end
                if (r.status == ST_DISPATCHED) begin
                    r.tag = waiting[r.cls].pop_front();
                end
            end
            r.high_occ   = OCC_W'(waiting[CLS_HIGH].size());
            r.middle_occ = OCC_W'(waiting[CLS_MIDDLE].size());
            r.low_occ    = OCC_W'(waiting[CLS_LOW].size());
            if (r.high_occ == 0 && r.middle_occ == 0 && r.low_occ == 0) begin
                high_run = '0;
                middle_run = '0;
            end
            pending.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply exp;
            if (pending.size() == 0) begin
                faults++;
                if (faults <= 10) begin
                    $display("unexpected result: status %0d tag %h class %0d occ %0d/%0d/%0d",
                             got.status, got.tag, got.cls,
                             got.high_occ, got.middle_occ, got.low_occ);
                end
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                faults++;
                if (faults <= 10) begin
                    $display("mismatch: expected status %0d tag %h class %0d occ %0d/%0d/%0d",
                             exp.status, exp.tag, exp.cls,
                             exp.high_occ, exp.middle_occ, exp.low_occ);
                    $display("          actual   status %0d tag %h class %0d occ %0d/%0d/%0d",
                             got.status, got.tag, got.cls,
                             got.high_occ, got.middle_occ, got.low_occ);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_HIGH_LIMIT;
    logic [LIMIT_W-1:0]   i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;   // task_tag, task_class
    logic                 s_axis_tuser = 1'b0; // operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;        // out_tag, out_class, high/middle/low occupancy
    logic [1:0]           m_axis_tuser;        // status

    t_dispatch_shadow shadow;
    int               send_idle_pct = 0;
    int               stall_pct = 0;

    three_class_weighted_task_dispatcher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: check each accepted beat, then pick the next ready
    always @(posedge i_clk) begin : result_side
        t_reply got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status     = t_status'(m_axis_tuser);
            got.tag        = m_axis_tdata[15:0];
            got.cls        = t_class'(m_axis_tdata[17:16]);
            got.high_occ   = m_axis_tdata[22:18];
            got.middle_occ = m_axis_tdata[27:23];
            got.low_occ    = m_axis_tdata[32:28];
            shadow.check_reply(got);
        end
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_item(input t_op op, input logic [TAG_W-1:0] tag,
                             input logic [CLASS_W-1:0] cls);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W - TAG_W - CLASS_W){1'b0}}, cls, tag};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.accept_item(op, tag, cls);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limits(input logic [LIMIT_W-1:0] high_lim,
                                input logic [LIMIT_W-1:0] middle_lim);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_HIGH_LIMIT;
        i_cfg_data <= high_lim;
        @(posedge i_clk);
        shadow.set_limit(CFG_HIGH_LIMIT, high_lim);
        i_cfg_idx  <= CFG_MIDDLE_LIMIT;
        i_cfg_data <= middle_lim;
        @(posedge i_clk);
        shadow.set_limit(CFG_MIDDLE_LIMIT, middle_lim);
        i_cfg_we   <= 1'b0;
    endtask

    // bursts lean towards filling or emptying, and towards one class
    task automatic run_mix(input int count);
        int               enq_pct;
        int               favour;
        logic [CLASS_W-1:0] cls;
        enq_pct = 50;
        favour  = 0;
        for (int i = 0; i < count; i++) begin
            if (i % 32 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 85;
                    1: enq_pct = 50;
                    default: enq_pct = 25;
                endcase
                favour = $urandom_range(2);
            end
            if ($urandom_range(99) < enq_pct) begin
                cls = ($urandom_range(99) < 60) ? CLASS_W'(favour)
                                                : CLASS_W'($urandom_range(3));
                send_item(OP_ENQUEUE, TAG_W'($urandom_range(16'hffff)), cls);
            end else begin
                send_item(OP_DISPATCH, TAG_W'($urandom_range(16'hffff)),
                          CLASS_W'($urandom_range(3)));
            end
        end
    endtask

    initial begin
        shadow = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty dispatch, bad class, extreme tags, a full low queue
        send_item(OP_DISPATCH, 16'hffff, CLS_NONE);
        send_item(OP_ENQUEUE, 16'hffff, CLS_NONE);
        send_item(OP_ENQUEUE, 16'h0000, CLS_HIGH);
        send_item(OP_ENQUEUE, 16'hffff, CLS_HIGH);
        send_item(OP_ENQUEUE, 16'haaaa, CLS_MIDDLE);
        for (int i = 0; i < DEPTH + 1; i++) begin
            send_item(OP_ENQUEUE, 16'h5555 ^ i[15:0], CLS_LOW);
        end
        repeat (3) send_item(OP_DISPATCH, 16'h0000, CLS_HIGH);
        drain_results();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_limits(4'd15, 4'd15);
                1: write_limits(4'd1, 4'd1);
                2: write_limits(4'd0, 4'd0);
                3: write_limits(4'd15, 4'd1);
                4: write_limits(4'd1, 4'd15);
                default: write_limits(LIMIT_W'($urandom_range(15)),
                                      LIMIT_W'($urandom_range(15)));
            endcase
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 73;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 73;
                end
                default: begin
                    send_idle_pct = 35;
                    stall_pct = 35;
                end
            endcase
            run_mix(84);
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        if (shadow.faults == 0 && shadow.pending.size() == 0) begin
            $display("** three_class_weighted_task_dispatcher: PASSED **");
        end else begin
            $display("** three_class_weighted_task_dispatcher: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** three_class_weighted_task_dispatcher: FAILED **");
        $finish;
    end

endmodule
